### design/text_cell_scanline_renderer_defines.svh
// Assertion helpers for the text cell renderer.
// Each expands to a labeled concurrent assertion clocked on clk_i, off in reset.
`ifndef TEXT_CELL_SCANLINE_RENDERER_DEFINES_SVH
`define TEXT_CELL_SCANLINE_RENDERER_DEFINES_SVH

// Same-cycle implication.
`define TCSR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcsr: check failed");

// Next-cycle implication.
`define TCSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcsr: check failed");

`endif

### design/tcsr_pkg.sv
`default_nettype none

package tcsr_pkg;

  // Screen geometry
  localparam int COLUMNS      = 80;
  localparam int ACTIVE_LINES = 400;
  localparam int TOP_BORDER   = 40;
  localparam int GLYPH_LINES  = 16;

  localparam int FONT_DEPTH = 4096;
  localparam int PAL_DEPTH  = 256;
  localparam int NPIX       = 8;

  localparam logic [7:0] GLYPH_FULL  = 8'hFF;
  localparam logic [7:0] GLYPH_EMPTY = 8'h00;

  typedef enum logic [1:0] {
    MODE_RENDER  = 2'd0,
    MODE_FONT_WR = 2'd1,
    MODE_PAL_WR  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_CURSOR_COLUMN  = 3'd0,
    REG_CURSOR_ROW     = 3'd1,
    REG_CURSOR_SHOWN   = 3'd2,
    REG_CURSOR_FIRST   = 3'd3,
    REG_CURSOR_LAST    = 3'd4,
    REG_UNDERLINE_LINE = 3'd5
  } reg_idx_e;

  // Table access for one accepted item
  typedef struct packed {
    logic        font_we;
    logic        pal_we;
    logic [11:0] wr_addr;
    logic [15:0] wr_data;
    logic        rd_en;
    logic [11:0] font_raddr;
    logic [7:0]  fg_idx;
    logic [7:0]  bg_idx;
  } tbl_req_t;

  // Per-cell flags resolved in the first stage
  typedef struct packed {
    logic black;
    logic inverse;
    logic underline;
    logic blank;
    logic cursor;
  } cell_ctl_t;

endpackage

`default_nettype wire

### design/tcsr_tables.sv
`default_nettype none

// Font and palette memories; synchronous read, read data registered.
module tcsr_tables (
  input  wire logic              clk_i,
  input  wire tcsr_pkg::tbl_req_t req_i,
  output logic [7:0]             font_o,
  output logic [15:0]            fg_o,
  output logic [15:0]            bg_o
);

  logic [7:0]  font_mem [tcsr_pkg::FONT_DEPTH];
  logic [15:0] pal_mem  [tcsr_pkg::PAL_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.font_we) begin
      font_mem[req_i.wr_addr] <= req_i.wr_data[7:0];
    end
    if (req_i.pal_we) begin
      pal_mem[req_i.wr_addr[7:0]] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      font_o <= font_mem[req_i.font_raddr];
      fg_o   <= pal_mem[req_i.fg_idx];
      bg_o   <= pal_mem[req_i.bg_idx];
    end
  end

endmodule

`default_nettype wire

### design/text_cell_scanline_renderer.sv
`default_nettype none

// Text-mode character generator. Each render item (mode 0) carries one text cell,
// its column, the display scanline and the blink phase, and returns the eight
// RGB565 pixels of that cell on that line, pixel_0 from glyph bit 7. Write items
// load the font (mode 1: address = glyph_line*256 + char, low data byte stored)
// or the palette (mode 2: low 8 address bits pick the entry) and return nothing;
// mode 3 is dropped. Font and palette hold garbage until written. Attributes:
// bit 0 inverse, bit 1 underline (forces the configured glyph line on), bit 2
// blink (glyph blanked while the phase is off); the cursor then inverts glyph
// lines first..last of its cell while shown and the phase is on. Lines outside
// the active band and columns past the screen render black. Throughput is one
// item per clock while the output is not stalled; a render result passes through
// the synchronous font/palette read register, then the pixel mux into the output
// register. Cursor and underline registers sit on the APB port at byte offsets
// 0x00..0x14 (4 bytes apart) and should only change while idle.
module text_cell_scanline_renderer #(
  parameter int unsigned COLUMNS      = tcsr_pkg::COLUMNS,
  parameter int unsigned ACTIVE_LINES = tcsr_pkg::ACTIVE_LINES,
  parameter int unsigned TOP_BORDER   = tcsr_pkg::TOP_BORDER
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,

  // Input item channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [9:0]  scan_line_i,
  input  wire logic [6:0]  cell_column_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [7:0]  fg_index_i,
  input  wire logic [7:0]  bg_index_i,
  input  wire logic [7:0]  attributes_i,
  input  wire logic        blink_phase_i,
  input  wire logic [11:0] table_address_i,
  input  wire logic [15:0] table_data_i,

  // Result item channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      pixel_0_o,
  output logic [15:0]      pixel_1_o,
  output logic [15:0]      pixel_2_o,
  output logic [15:0]      pixel_3_o,
  output logic [15:0]      pixel_4_o,
  output logic [15:0]      pixel_5_o,
  output logic [15:0]      pixel_6_o,
  output logic [15:0]      pixel_7_o
);

  `include "text_cell_scanline_renderer_defines.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [6:0] cur_col_q;
  logic [4:0] cur_row_q;
  logic       cur_shown_q;
  logic [3:0] cur_first_q;
  logic [3:0] cur_last_q;
  logic [3:0] ul_line_q;

  logic               cfg_wr;
  tcsr_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = tcsr_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= 7'd0;
      cur_row_q   <= 5'd0;
      cur_shown_q <= 1'b0;
      cur_first_q <= 4'd14;
      cur_last_q  <= 4'd15;
      ul_line_q   <= 4'd15;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tcsr_pkg::REG_CURSOR_COLUMN:  cur_col_q   <= pwdata[6:0];
        tcsr_pkg::REG_CURSOR_ROW:     cur_row_q   <= pwdata[4:0];
        tcsr_pkg::REG_CURSOR_SHOWN:   cur_shown_q <= pwdata[0];
        tcsr_pkg::REG_CURSOR_FIRST:   cur_first_q <= pwdata[3:0];
        tcsr_pkg::REG_CURSOR_LAST:    cur_last_q  <= pwdata[3:0];
        tcsr_pkg::REG_UNDERLINE_LINE: ul_line_q   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (cfg_idx)
      tcsr_pkg::REG_CURSOR_COLUMN:  prdata = {25'd0, cur_col_q};
      tcsr_pkg::REG_CURSOR_ROW:     prdata = {27'd0, cur_row_q};
      tcsr_pkg::REG_CURSOR_SHOWN:   prdata = {31'd0, cur_shown_q};
      tcsr_pkg::REG_CURSOR_FIRST:   prdata = {28'd0, cur_first_q};
      tcsr_pkg::REG_CURSOR_LAST:    prdata = {28'd0, cur_last_q};
      tcsr_pkg::REG_UNDERLINE_LINE: prdata = {28'd0, ul_line_q};
      default:                      prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake / pipeline control
  // Stage 1 holds table read data plus cell flags, stage 2 is the output reg.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_ready, s1_free, s1_adv, in_acc, in_render;

  tcsr_pkg::mode_e in_mode;

  assign in_mode    = tcsr_pkg::mode_e'(mode_i);
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_ready;
  assign s1_adv     = s1_valid_q && out_ready;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && s1_free;
  assign in_render  = in_acc && (in_mode == tcsr_pkg::MODE_RENDER);

  assign s1_valid_d  = s1_free ? in_render : s1_valid_q;
  assign out_valid_d = out_ready ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Stage 1: decode the cell against the scan geometry, read the tables
  // ---------------------------------------------------------------------------
  logic [9:0] line_ofs;
  logic [5:0] text_row;
  logic [3:0] glyph_line;
  logic       outside;

  tcsr_pkg::cell_ctl_t ctl_d, ctl_q;
  tcsr_pkg::tbl_req_t  tbl_req;

  logic [7:0]  font_rd;
  logic [15:0] fg_rd, bg_rd;

  assign line_ofs   = scan_line_i - 10'(TOP_BORDER);
  assign text_row   = line_ofs[9:4];
  assign glyph_line = line_ofs[3:0];
  assign outside    = (scan_line_i < 10'(TOP_BORDER))
                   || ({1'b0, cell_column_i} >= 8'(COLUMNS))
                   || (line_ofs >= 10'(ACTIVE_LINES));

  always_comb begin
    ctl_d.black     = outside;
    ctl_d.inverse   = attributes_i[0];
    ctl_d.underline = attributes_i[1] && (glyph_line == ul_line_q);
    ctl_d.blank     = attributes_i[2] && !blink_phase_i;
    ctl_d.cursor    = cur_shown_q && blink_phase_i
                   && (text_row == {1'b0, cur_row_q})
                   && (cell_column_i == cur_col_q)
                   && (glyph_line >= cur_first_q)
                   && (glyph_line <= cur_last_q);
  end

  always_comb begin
    tbl_req.font_we    = in_acc && (in_mode == tcsr_pkg::MODE_FONT_WR);
    tbl_req.pal_we     = in_acc && (in_mode == tcsr_pkg::MODE_PAL_WR);
    tbl_req.wr_addr    = table_address_i;
    tbl_req.wr_data    = table_data_i;
    tbl_req.rd_en      = in_render;
    tbl_req.font_raddr = {glyph_line, char_code_i};
    tbl_req.fg_idx     = fg_index_i;
    tbl_req.bg_idx     = bg_index_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_render) begin
      ctl_q <= ctl_d;
    end
  end

  tcsr_tables u_tables (
    .clk_i  (clk_i),
    .req_i  (tbl_req),
    .font_o (font_rd),
    .fg_o   (fg_rd),
    .bg_o   (bg_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: glyph modifiers in fixed order (underline, blink, cursor), then
  // per-pixel color select.
  // ---------------------------------------------------------------------------
  logic [7:0]  glyph;
  logic [15:0] fg_col, bg_col;
  logic [15:0] pixel_d [tcsr_pkg::NPIX];
  logic [15:0] pixel_q [tcsr_pkg::NPIX];

  always_comb begin
    glyph = font_rd;
    if (ctl_q.underline) begin
      glyph = tcsr_pkg::GLYPH_FULL;
    end
    if (ctl_q.blank) begin
      glyph = tcsr_pkg::GLYPH_EMPTY;
    end
    if (ctl_q.cursor) begin
      glyph = ~glyph;
    end
    fg_col = ctl_q.inverse ? bg_rd : fg_rd;
    bg_col = ctl_q.inverse ? fg_rd : bg_rd;
    for (int k = 0; k < tcsr_pkg::NPIX; k++) begin
      if (ctl_q.black) begin
        pixel_d[k] = 16'd0;
      end else begin
        pixel_d[k] = glyph[tcsr_pkg::NPIX - 1 - k] ? fg_col : bg_col;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      pixel_q <= pixel_d;
    end
  end

  assign pixel_0_o = pixel_q[0];
  assign pixel_1_o = pixel_q[1];
  assign pixel_2_o = pixel_q[2];
  assign pixel_3_o = pixel_q[3];
  assign pixel_4_o = pixel_q[4];
  assign pixel_5_o = pixel_q[5];
  assign pixel_6_o = pixel_q[6];
  assign pixel_7_o = pixel_q[7];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TCSR_ASSERT_NEXT(a_write_no_result, in_acc && (in_mode != tcsr_pkg::MODE_RENDER), !s1_valid_q)
  `TCSR_ASSERT_NEXT(a_render_enters, in_render, s1_valid_q)
  `TCSR_ASSERT_IMPLY(a_stall_full, in_stall_o, s1_valid_q && out_valid_q && out_stall_i)
  `TCSR_ASSERT_IMPLY(a_out_from_s1, $rose(out_valid_q), $past(s1_valid_q))
  `TCSR_ASSERT_NEXT(a_black_zero, s1_adv && ctl_q.black, (pixel_q[0] == 16'd0) && (pixel_q[7] == 16'd0))

endmodule

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import tcsr_pkg::*;

  // Clocking and run control
  localparam int HALF_PERIOD    = 1;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 6;     // margin after the last owed row for write items
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either channel
  localparam int IDLE_PCT       = 36;
  localparam int NUM_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 238;
  localparam int DIRECTED_ROWS  = 24;

  // Spare mode code: the block must drop it
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // One input item, field for field
  typedef struct packed {
    logic [1:0]  mode;
    logic [9:0]  scan;
    logic [6:0]  col;
    logic [7:0]  ch;
    logic [7:0]  fg;
    logic [7:0]  bg;
    logic [7:0]  attr;
    logic        phase;
    logic [11:0] addr;
    logic [15:0] data;
  } cell_item_t;

  // Eight RGB565 pixels; index k is pixel_k
  typedef logic [NPIX-1:0][15:0] pix_row_t;

  // Directed row: item plus an optional hand-typed result (all pixels equal)
  typedef struct packed {
    cell_item_t  item;
    logic        fixed_en;
    logic [15:0] fixed_pix;
  } dir_row_t;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [4:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i          = '0;
  logic [9:0]  scan_line_i     = '0;
  logic [6:0]  cell_column_i   = '0;
  logic [7:0]  char_code_i     = '0;
  logic [7:0]  fg_index_i      = '0;
  logic [7:0]  bg_index_i      = '0;
  logic [7:0]  attributes_i    = '0;
  logic        blink_phase_i   = 1'b0;
  logic [11:0] table_address_i = '0;
  logic [15:0] table_data_i    = '0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] pixel_0_o, pixel_1_o, pixel_2_o, pixel_3_o;
  logic [15:0] pixel_4_o, pixel_5_o, pixel_6_o, pixel_7_o;

  text_cell_scanline_renderer u_top (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .mode_i, .scan_line_i, .cell_column_i, .char_code_i,
    .fg_index_i, .bg_index_i, .attributes_i, .blink_phase_i, .table_address_i,
    .table_data_i,
    .out_valid_o, .out_stall_i,
    .pixel_0_o, .pixel_1_o, .pixel_2_o, .pixel_3_o,
    .pixel_4_o, .pixel_5_o, .pixel_6_o, .pixel_7_o
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the block: font and palette contents, which entries hold data,
  // and the cursor/underline registers as last written over APB.
  // ---------------------------------------------------------------------------
  logic [7:0]  font_mem [FONT_DEPTH];
  logic [15:0] pal_mem  [PAL_DEPTH];
  bit          font_ok  [FONT_DEPTH];
  bit          pal_ok   [PAL_DEPTH];

  logic [6:0] cur_col   = 7'd0;
  logic [4:0] cur_row   = 5'd0;
  logic       cur_shown = 1'b0;
  logic [3:0] cur_first = 4'd14;
  logic [3:0] cur_last  = 4'd15;
  logic [3:0] ul_line   = 4'd15;

  pix_row_t cell_pixels_due [$];   // pixel rows owed by the block, oldest first

  bit quiet = 1'b0;                // no idling on either side while set

  int errors         = 0;
  int items_sent     = 0;
  int cells_checked  = 0;
  int cursor_cells   = 0;
  int black_cells    = 0;
  int font_writes    = 0;
  int pal_writes     = 0;
  int spare_items    = 0;
  int idle_cycles    = 0;

  // Directed table, walked in order right after reset (reset register values).
  // Palette: 0 black, 1 red, 2 green, 255 white. Font: 'A' line 0 = A5,
  // 'A' line 15 = 18, char 255 line 15 = FF, char 0 line 0 = 00.
  dir_row_t dir_rows [DIRECTED_ROWS] = '{
    // table loads; high address bits on palette writes and high data byte on font
    // writes must be ignored
    '{'{MODE_PAL_WR,  10'd0,   7'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 12'h000, 16'h0000},
      1'b0, 16'h0000},
    '{'{MODE_PAL_WR,  10'd0,   7'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 12'hFFF, 16'hFFFF},
      1'b0, 16'h0000},
    '{'{MODE_PAL_WR,  10'd0,   7'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 12'h101, 16'hF800},
      1'b0, 16'h0000},
    '{'{MODE_PAL_WR,  10'd0,   7'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 12'h002, 16'h07E0},
      1'b0, 16'h0000},
    '{'{MODE_FONT_WR, 10'd0,   7'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 12'h041, 16'hFFA5},
      1'b0, 16'h0000},
    '{'{MODE_FONT_WR, 10'd0,   7'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 12'hFFF, 16'h00FF},
      1'b0, 16'h0000},
    '{'{MODE_FONT_WR, 10'd0,   7'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 12'hF41, 16'h0018},
      1'b0, 16'h0000},
    '{'{MODE_FONT_WR, 10'd0,   7'd0,  8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 12'h000, 16'hFF00},
      1'b0, 16'h0000},
    // spare mode with most fields all ones: no result, no table change
    '{'{MODE_SPARE, 10'h3FF, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 12'h000, 16'hFFFF},
      1'b0, 16'h0000},
    // border lines and off-screen columns render black
    '{'{MODE_RENDER,  10'd0,   7'd0,  8'h41, 8'hFF, 8'h01, 8'h00, 1'b0, 12'h000, 16'h0000},
      1'b1, 16'h0000},
    '{'{MODE_RENDER,  10'd39,  7'd79, 8'h41, 8'hFF, 8'h01, 8'h00, 1'b1, 12'h000, 16'h0000},
      1'b1, 16'h0000},
    '{'{MODE_RENDER,  10'd440, 7'd0,  8'h41, 8'hFF, 8'h01, 8'h00, 1'b1, 12'h000, 16'h0000},
      1'b1, 16'h0000},
    '{'{MODE_RENDER,  10'd1023, 7'd127, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 12'hFFF, 16'hFFFF},
      1'b1, 16'h0000},
    '{'{MODE_RENDER,  10'd40,  7'd80, 8'h41, 8'hFF, 8'h01, 8'h00, 1'b1, 12'h000, 16'h0000},
      1'b1, 16'h0000},
    '{'{MODE_RENDER,  10'd40,  7'd127, 8'h41, 8'hFF, 8'h01, 8'h00, 1'b1, 12'h000, 16'h0000},
      1'b1, 16'h0000},
    // first active line, empty glyph: all background (black)
    '{'{MODE_RENDER,  10'd40,  7'd0,  8'h00, 8'hFF, 8'h00, 8'h00, 1'b1, 12'h000, 16'h0000},
      1'b1, 16'h0000},
    // mixed glyph, plain and inverse
    '{'{MODE_RENDER,  10'd40,  7'd79, 8'h41, 8'h02, 8'h01, 8'h00, 1'b1, 12'h000, 16'h0000},
      1'b0, 16'h0000},
    '{'{MODE_RENDER,  10'd40,  7'd79, 8'h41, 8'h02, 8'h01, 8'h01, 1'b1, 12'h000, 16'h0000},
      1'b0, 16'h0000},
    // glyph line 15: underline forces it on, blink with phase off blanks it
    '{'{MODE_RENDER,  10'd55,  7'd10, 8'h41, 8'h02, 8'h01, 8'h02, 1'b0, 12'h000, 16'h0000},
      1'b1, 16'h07E0},
    '{'{MODE_RENDER,  10'd55,  7'd10, 8'h41, 8'h02, 8'h01, 8'h04, 1'b0, 12'h000, 16'h0000},
      1'b1, 16'hF800},
    '{'{MODE_RENDER,  10'd55,  7'd10, 8'h41, 8'h02, 8'h01, 8'h06, 1'b0, 12'h000, 16'h0000},
      1'b1, 16'hF800},
    '{'{MODE_RENDER,  10'd55,  7'd10, 8'h41, 8'h02, 8'h01, 8'h04, 1'b1, 12'h000, 16'h0000},
      1'b0, 16'h0000},
    // last active line, full glyph; upper attribute bits ignored
    '{'{MODE_RENDER,  10'd439, 7'd79, 8'hFF, 8'hFF, 8'h00, 8'hF8, 1'b1, 12'h000, 16'h0000},
      1'b1, 16'hFFFF},
    // every attribute: inverse swaps to black on white, underline keeps line full
    '{'{MODE_RENDER,  10'd439, 7'd79, 8'hFF, 8'hFF, 8'h00, 8'hFF, 1'b1, 12'h000, 16'h0000},
      1'b1, 16'h0000}
  };

  function automatic bit on_screen(logic [9:0] scan, logic [6:0] col);
    return (int'(scan) >= TOP_BORDER) && (int'(scan) < TOP_BORDER + ACTIVE_LINES) &&
           (int'(col) < COLUMNS);
  endfunction

  // Expected pixels of one render item against the current shadow state.
  // Order: inverse, underline, blink, cursor.
  function automatic pix_row_t render_cell(cell_item_t it);
    pix_row_t    px;
    logic [15:0] fg, bg, tmp;
    logic [7:0]  glyph;
    int          y, row, sub;
    px = '0;
    if (!on_screen(it.scan, it.col)) begin
      black_cells++;
      return px;
    end
    y   = int'(it.scan) - TOP_BORDER;
    row = y / GLYPH_LINES;
    sub = y % GLYPH_LINES;
    fg  = pal_mem[it.fg];
    bg  = pal_mem[it.bg];
    if (it.attr[0]) begin
      tmp = fg;
      fg  = bg;
      bg  = tmp;
    end
    glyph = font_mem[sub * 256 + int'(it.ch)];
    if (it.attr[1] && sub == int'(ul_line)) glyph = GLYPH_FULL;
    if (it.attr[2] && !it.phase) glyph = GLYPH_EMPTY;
    // first > last gives an empty range, so nothing is inverted
    if (cur_shown && it.phase && row == int'(cur_row) && it.col == cur_col &&
        sub >= int'(cur_first) && sub <= int'(cur_last)) begin
      glyph = ~glyph;
      cursor_cells++;
    end
    for (int k = 0; k < NPIX; k++) px[k] = glyph[7-k] ? fg : bg;
    return px;
  endfunction

  function automatic cell_item_t rand_item();
    cell_item_t it;
    it.mode  = 2'($urandom_range(3));
    it.scan  = 10'($urandom);
    it.col   = 7'($urandom);
    it.ch    = 8'($urandom);
    it.fg    = 8'($urandom);
    it.bg    = 8'($urandom);
    it.attr  = 8'($urandom);
    it.phase = 1'($urandom);
    it.addr  = 12'($urandom);
    it.data  = 16'($urandom);
    return it;
  endfunction

  // Present one item, idling first at random, and hold it until accepted.
  // On acceptance the shadow state moves and any owed pixel row is queued.
  task automatic send_item(input cell_item_t it, input logic fixed_en,
                           input logic [15:0] fixed_pix);
    pix_row_t want;
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    mode_i          <= it.mode;
    scan_line_i     <= it.scan;
    cell_column_i   <= it.col;
    char_code_i     <= it.ch;
    fg_index_i      <= it.fg;
    bg_index_i      <= it.bg;
    attributes_i    <= it.attr;
    blink_phase_i   <= it.phase;
    table_address_i <= it.addr;
    table_data_i    <= it.data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    case (it.mode)
      MODE_FONT_WR: begin
        font_mem[it.addr] = it.data[7:0];
        font_ok[it.addr]  = 1'b1;
        font_writes++;
      end
      MODE_PAL_WR: begin
        pal_mem[it.addr[7:0]] = it.data;
        pal_ok[it.addr[7:0]]  = 1'b1;
        pal_writes++;
      end
      MODE_RENDER: begin
        want = render_cell(it);
        if (fixed_en) want = {NPIX{fixed_pix}};
        cell_pixels_due.push_back(want);
      end
      default: spare_items++;
    endcase
  endtask

  // Drop valid, wait for every owed row, then let write items in flight retire.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cell_pixels_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_CURSOR_COLUMN:  cur_col   = val[6:0];
      REG_CURSOR_ROW:     cur_row   = val[4:0];
      REG_CURSOR_SHOWN:   cur_shown = val[0];
      REG_CURSOR_FIRST:   cur_first = val[3:0];
      REG_CURSOR_LAST:    cur_last  = val[3:0];
      REG_UNDERLINE_LINE: ul_line   = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input int col, input int row, input int shown,
                           input int first, input int last, input int ul);
    apb_write(REG_CURSOR_COLUMN, 32'(col));
    apb_write(REG_CURSOR_ROW, 32'(row));
    apb_write(REG_CURSOR_SHOWN, 32'(shown));
    apb_write(REG_CURSOR_FIRST, 32'(first));
    apb_write(REG_CURSOR_LAST, 32'(last));
    apb_write(REG_UNDERLINE_LINE, 32'(ul));
  endtask

  // Result side: random stall, none during the quiet stretch
  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  // Scoreboard: every accepted result against the oldest owed row
  always @(posedge clk_i) begin
    pix_row_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {pixel_7_o, pixel_6_o, pixel_5_o, pixel_4_o,
             pixel_3_o, pixel_2_o, pixel_1_o, pixel_0_o};
      if (cell_pixels_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing owed, pixel_0 %h", $time, got[0]);
      end else begin
        want = cell_pixels_due.pop_front();
        cells_checked++;
        for (int k = 0; k < NPIX; k++) begin
          if (got[k] !== want[k]) begin
            errors++;
            $display("%0t: pixel_%0d expected %h got %h", $time, k, want[k], got[k]);
          end
        end
      end
    end
  end

  // Watchdog: too long with nothing moving on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cell_item_t it, wr;
    int         pick, sub, fidx, first, font_used, pal_used;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table under reset register values
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].fixed_en,
                                    dir_rows[i].fixed_pix);
    drain();

    // Random phases, one register setting each. Renders of on-screen cells are
    // preceded by the font and palette loads they need, so no entry is read
    // before it holds data.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: configure(COLUMNS - 1, 24, 1, 0, 15, 0);    // high corner, whole cell
        1: configure(0, 0, 1, 14, 15, 15);             // low corner, reset-like range
        2: configure(40, 12, 1, 15, 0, 7);             // first past last: no inversion
        3: configure(5, 3, 0, 0, 15, 15);              // cursor hidden
        default: begin
          first = $urandom_range(15);
          configure($urandom_range(COLUMNS - 1), $urandom_range(24), 1, first,
                    $urandom_range(15, first), $urandom_range(15));
        end
      endcase
      quiet = (ph == 1);   // one whole phase at full rate on both sides

      while (items_sent < DIRECTED_ROWS + (ph + 1) * ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        it   = rand_item();
        if (pick < 6) begin
          it.mode = MODE_SPARE;
          send_item(it, 1'b0, '0);
        end else if (pick < 12) begin
          it.mode = $urandom_range(1) ? MODE_FONT_WR : MODE_PAL_WR;
          send_item(it, 1'b0, '0);
        end else begin
          it.mode = MODE_RENDER;
          if ($urandom_range(99) < 30) begin
            // aim at the cursor cell, shown or not
            it.scan = 10'(TOP_BORDER + int'(cur_row) * GLYPH_LINES +
                          $urandom_range(GLYPH_LINES - 1));
            it.col  = cur_col;
          end else if ($urandom_range(99) < 85) begin
            it.scan = 10'(TOP_BORDER + $urandom_range(ACTIVE_LINES - 1));
            if ($urandom_range(99) < 92) it.col = 7'($urandom_range(COLUMNS - 1));
          end
          if (on_screen(it.scan, it.col) && $urandom_range(99) < 20) begin
            sub     = (int'(it.scan) - TOP_BORDER) % GLYPH_LINES;
            it.scan = 10'(int'(it.scan) - sub + int'(ul_line));
          end
          // small working sets so loaded entries get reused
          if ($urandom_range(1)) it.ch = 8'h40 + 8'($urandom_range(15));
          if ($urandom_range(1)) it.fg = 8'($urandom_range(15));
          if ($urandom_range(1)) it.bg = 8'($urandom_range(15));
          if (on_screen(it.scan, it.col)) begin
            fidx = ((int'(it.scan) - TOP_BORDER) % GLYPH_LINES) * 256 + int'(it.ch);
            if (!font_ok[fidx]) begin
              wr      = rand_item();
              wr.mode = MODE_FONT_WR;
              wr.addr = 12'(fidx);
              send_item(wr, 1'b0, '0);
            end
            if (!pal_ok[it.fg]) begin
              wr           = rand_item();
              wr.mode      = MODE_PAL_WR;
              wr.addr[7:0] = it.fg;
              send_item(wr, 1'b0, '0);
            end
            if (!pal_ok[it.bg]) begin
              wr           = rand_item();
              wr.mode      = MODE_PAL_WR;
              wr.addr[7:0] = it.bg;
              send_item(wr, 1'b0, '0);
            end
          end
          send_item(it, 1'b0, '0);
        end
      end
      drain();
    end
    quiet = 1'b0;

    if (cell_pixels_due.size() != 0) begin
      errors++;
      $display("%0t: %0d pixel rows never arrived", $time, cell_pixels_due.size());
    end

    font_used = 0;
    pal_used  = 0;
    foreach (font_ok[i]) font_used += font_ok[i];
    foreach (pal_ok[i]) pal_used += pal_ok[i];
    $display("Sent %0d items: %0d cells checked (%0d cursor-inverted, %0d black),",
             items_sent, cells_checked, cursor_cells, black_cells);
    $display("  %0d font / %0d palette loads (%0d / %0d entries), %0d spare-mode, %0d phases.",
             font_writes, pal_writes, font_used, pal_used, spare_items, NUM_PHASES);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/tcsr_pkg.sv
design/tcsr_tables.sv
design/text_cell_scanline_renderer.sv
dv/tb.sv
